@@ hw/rtl/wttf_pkg.sv @@
// ----------------------------------------------------------------------------
// wttf_pkg: shared types and constants of the weighted track time fit
// Transfer payloads, register indexes and the widths of the datapath.
// ----------------------------------------------------------------------------
package wttf_pkg;

	localparam int NUM_PLANES = 6;
	localparam int TIME_W     = 20;
	localparam int MASK_W     = 6;
	localparam int CFG_W      = 48;
	localparam int LANE_W     = 16;
	localparam int ERR_W      = 16;
	localparam int CHI_W      = 24;

	// datapath widths
	localparam int W_W     = 2 * LANE_W;   // squared inverse resolution
	localparam int SUMW_W  = W_W + 3;      // sum over the planes
	localparam int TSUM_W  = TIME_W + 1;   // hit plus reference
	localparam int DIFF_W  = TIME_W + 2;   // hit minus reference minus offset
	localparam int AD_W    = DIFF_W - 1;
	localparam int PROD_W  = TSUM_W + W_W + 1;
	localparam int NUM_W   = PROD_W + 3;
	localparam int P_W     = AD_W + LANE_W;
	localparam int SQ_W    = 2 * CHI_W;
	localparam int ACC_W   = SQ_W + 3;
	localparam int MREM_W  = NUM_W;        // mean dividend and remainder
	localparam int MDEN_W  = SUMW_W + 1;
	localparam int MQ_W    = TIME_W;
	localparam int LQ_W    = 33;           // quotient of 2^32 by the weight sum
	localparam int ROOT_W  = 17;

	// iterative sections of the pipeline
	localparam int MDIV_STAGES = MQ_W;
	localparam int LDIV_STAGES = LQ_W;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int NREG        = LDIV_STAGES + SQRT_STAGES;

	localparam logic [CHI_W-1:0] CHI_MAX = '1;
	localparam logic [ERR_W-1:0] ERR_MAX = '1;
	localparam logic signed [TIME_W-1:0] MEAN_MAX = {1'b0, {(TIME_W-1){1'b1}}};

	typedef enum logic [1:0] {
		REG_INV_LOW  = 2'd0,
		REG_INV_HIGH = 2'd1,
		REG_OFF_LOW  = 2'd2,
		REG_OFF_HIGH = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [TIME_W-1:0] reference_time;
		logic signed [TIME_W-1:0] hit_time_0;
		logic signed [TIME_W-1:0] hit_time_1;
		logic signed [TIME_W-1:0] hit_time_2;
		logic signed [TIME_W-1:0] hit_time_3;
		logic signed [TIME_W-1:0] hit_time_4;
		logic signed [TIME_W-1:0] hit_time_5;
		logic [MASK_W-1:0]        present_mask;
	} in_item_t;

	typedef struct packed {
		logic signed [TIME_W-1:0] mean_time;
		logic [ERR_W-1:0]         mean_time_error;
		logic [CHI_W-1:0]         time_chi_square;
		logic                     no_planes;
	} out_item_t;

endpackage

@@ hw/rtl/weighted_track_time_fit.sv @@
// ----------------------------------------------------------------------------
// weighted_track_time_fit: weighted mean track time, its error and chi-square
// Four arithmetic stages, bit-serial pipelined dividers and a square root.
// ----------------------------------------------------------------------------
// pipeline of 4 front stages, 33 divider stages for 2^32 / weight sum,
//   17 square root stages and an output register
// throughput: one track per cycle; the whole pipeline holds while a result
//   waits on out_stall
// reset: clears all valid bits and the four configuration registers
module weighted_track_time_fit import wttf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] inv_lo_q, inv_hi_q, off_lo_q, off_hi_q;
	logic             adv;
	logic             out_valid_q;
	out_item_t        out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_lo_q <= '0;
			inv_hi_q <= '0;
			off_lo_q <= '0;
			off_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INV_LOW:  inv_lo_q <= cfg_data;
				REG_INV_HIGH: inv_hi_q <= cfg_data;
				REG_OFF_LOW:  off_lo_q <= cfg_data;
				REG_OFF_HIGH: off_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves unless a finished result is held back
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	// stage 1: weights, time sums and offset-corrected distances
	logic signed [TIME_W-1:0] hit [NUM_PLANES];
	logic [LANE_W-1:0]        inv_c [NUM_PLANES];
	logic signed [LANE_W-1:0] off_c [NUM_PLANES];
	logic signed [DIFF_W-1:0] diff_c [NUM_PLANES];

	logic                     v_s1;
	logic [W_W-1:0]           w_s1 [NUM_PLANES];
	logic signed [TSUM_W-1:0] tsum_s1 [NUM_PLANES];
	logic [AD_W-1:0]          ad_s1 [NUM_PLANES];
	logic [LANE_W-1:0]        inv_s1 [NUM_PLANES];

	always_comb begin
		hit[0] = in_data.hit_time_0;
		hit[1] = in_data.hit_time_1;
		hit[2] = in_data.hit_time_2;
		hit[3] = in_data.hit_time_3;
		hit[4] = in_data.hit_time_4;
		hit[5] = in_data.hit_time_5;
		for (int i = 0; i < NUM_PLANES; i++) begin
			if (i < 3) begin
				inv_c[i] = inv_lo_q[LANE_W*i +: LANE_W];
				off_c[i] = $signed(off_lo_q[LANE_W*i +: LANE_W]);
			end else begin
				inv_c[i] = inv_hi_q[LANE_W*(i-3) +: LANE_W];
				off_c[i] = $signed(off_hi_q[LANE_W*(i-3) +: LANE_W]);
			end
			diff_c[i] = DIFF_W'(hit[i]) - DIFF_W'(in_data.reference_time)
				- DIFF_W'(off_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				inv_s1[i]  <= inv_c[i];
				tsum_s1[i] <= TSUM_W'(hit[i]) + TSUM_W'(in_data.reference_time);
				if (in_data.present_mask[i]) begin
					w_s1[i] <= inv_c[i] * inv_c[i];
					if (diff_c[i] < 0) ad_s1[i] <= AD_W'(-diff_c[i]);
					else ad_s1[i] <= AD_W'(diff_c[i]);
				end else begin
					w_s1[i]  <= '0;
					ad_s1[i] <= '0;
				end
			end
		end
	end

	// stage 2: weighted time products, scaled distances, weight sum
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2 [NUM_PLANES];
	logic [P_W-1:0]           p_s2 [NUM_PLANES];
	logic [SUMW_W-1:0]        sumw_s2;
	logic [SUMW_W-1:0]        sumw_c;

	always_comb begin
		sumw_c = '0;
		for (int i = 0; i < NUM_PLANES; i++) sumw_c = sumw_c + SUMW_W'(w_s1[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sumw_s2 <= sumw_c;
			for (int i = 0; i < NUM_PLANES; i++) begin
				prod_s2[i] <= PROD_W'(tsum_s1[i]) * PROD_W'($signed({1'b0, w_s1[i]}));
				p_s2[i]    <= P_W'(ad_s1[i]) * P_W'(inv_s1[i]);
			end
		end
	end

	// stage 3: mean numerator, squared terms, term overflow
	logic                    v_s3;
	logic signed [NUM_W-1:0] num_s3;
	logic [SQ_W-1:0]         sq_s3 [NUM_PLANES];
	logic                    psat_s3;
	logic [SUMW_W-1:0]       sumw_s3;
	logic signed [NUM_W-1:0] num_c;
	logic                    psat_c;

	always_comb begin
		num_c  = '0;
		psat_c = 1'b0;
		for (int i = 0; i < NUM_PLANES; i++) begin
			num_c  = num_c + NUM_W'(prod_s2[i]);
			psat_c = psat_c | (p_s2[i][P_W-1:CHI_W] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s3  <= num_c;
			psat_s3 <= psat_c;
			sumw_s3 <= sumw_s2;
			for (int i = 0; i < NUM_PLANES; i++)
				sq_s3[i] <= p_s2[i][CHI_W-1:0] * p_s2[i][CHI_W-1:0];
		end
	end

	// stage 4 is index 0 of the iterative section
	logic              v_sn    [0:NREG];
	logic              neg_sn  [0:NREG];
	logic              zero_sn [0:NREG];
	logic [CHI_W-1:0]  chi_sn  [1:NREG];
	logic [MQ_W-1:0]   mq_sn   [0:NREG];
	logic [MREM_W-1:0] mrem_sn [0:MDIV_STAGES];
	logic [MDEN_W-1:0] mden_sn [0:MDIV_STAGES];
	logic [SUMW_W-1:0] lrem_sn [0:LDIV_STAGES];
	logic [SUMW_W-1:0] lden_sn [0:LDIV_STAGES];
	logic [LQ_W-1:0]   lq_sn   [0:LDIV_STAGES];
	logic [LQ_W-1:0]   lim_sn  [LDIV_STAGES+1:NREG];
	logic [ROOT_W-1:0] root_sn [LDIV_STAGES+1:NREG];
	logic [ACC_W-1:0]  acc_s4;
	logic              sat_s4;

	logic [ACC_W-1:0]    acc_c;
	logic [MREM_W-2:0]   an_c;

	always_comb begin
		acc_c = '0;
		for (int i = 0; i < NUM_PLANES; i++) acc_c = acc_c + ACC_W'(sq_s3[i]);
		if (num_s3 < 0) an_c = (MREM_W-1)'(-num_s3);
		else an_c = (MREM_W-1)'(num_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sn[0] <= 1'b0;
		else if (adv) v_sn[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s4     <= acc_c;
			sat_s4     <= psat_s3;
			neg_sn[0]  <= num_s3 < 0;
			zero_sn[0] <= sumw_s3 == '0;
			mrem_sn[0] <= MREM_W'(an_c) + MREM_W'(sumw_s3);
			mden_sn[0] <= {sumw_s3, 1'b0};
			mq_sn[0]   <= '0;
			lrem_sn[0] <= '0;
			lden_sn[0] <= sumw_s3;
			lq_sn[0]   <= '0;
		end
	end

	// iterative section: mean divider, weight-sum reciprocal, square root
	for (genvar j = 1; j <= NREG; j++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sn[j] <= 1'b0;
			else if (adv) v_sn[j] <= v_sn[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				neg_sn[j]  <= neg_sn[j-1];
				zero_sn[j] <= zero_sn[j-1];
			end
		end

		// chi-square rounding and saturation, then carried along
		if (j == 1) begin : g_chi
			logic [ACC_W-CHI_W:0] chi_r;
			assign chi_r = (ACC_W-CHI_W+1)'((acc_s4 + (ACC_W'(1) << (CHI_W-1))) >> CHI_W);
			always_ff @(posedge clk) begin
				if (adv) begin
					if (sat_s4 || chi_r > (ACC_W-CHI_W+1)'(CHI_MAX)) chi_sn[j] <= CHI_MAX;
					else chi_sn[j] <= chi_r[CHI_W-1:0];
				end
			end
		end else begin : g_chi_pass
			always_ff @(posedge clk) begin
				if (adv) chi_sn[j] <= chi_sn[j-1];
			end
		end

		// mean divider, one quotient bit per stage from the top
		if (j <= MDIV_STAGES) begin : g_mdiv
			logic [MREM_W-1:0] trial;
			logic              ge;
			assign trial = MREM_W'(mden_sn[j-1]) << (MDIV_STAGES - j);
			assign ge    = mrem_sn[j-1] >= trial;
			always_ff @(posedge clk) begin
				if (adv) begin
					mden_sn[j] <= mden_sn[j-1];
					mrem_sn[j] <= ge ? mrem_sn[j-1] - trial : mrem_sn[j-1];
					mq_sn[j]   <= mq_sn[j-1] | (MQ_W'(ge) << (MDIV_STAGES - j));
				end
			end
		end else begin : g_mq_pass
			always_ff @(posedge clk) begin
				if (adv) mq_sn[j] <= mq_sn[j-1];
			end
		end

		// 2^32 / weight sum, dividend bits shifted in from the top
		if (j <= LDIV_STAGES) begin : g_ldiv
			logic [SUMW_W:0] sh;
			logic            ge;
			assign sh = {lrem_sn[j-1], (j == 1) ? 1'b1 : 1'b0};
			assign ge = sh >= {1'b0, lden_sn[j-1]};
			always_ff @(posedge clk) begin
				if (adv) begin
					lden_sn[j] <= lden_sn[j-1];
					lrem_sn[j] <= ge ? SUMW_W'(sh - {1'b0, lden_sn[j-1]}) : SUMW_W'(sh);
					lq_sn[j]   <= {lq_sn[j-1][LQ_W-2:0], ge};
				end
			end
		end else begin : g_sqrt
			// integer square root, one result bit per stage from the top
			logic [LQ_W-1:0]     lim_in;
			logic [ROOT_W-1:0]   root_in;
			logic [ROOT_W-1:0]   trial;
			logic [2*ROOT_W-1:0] trial_sq;
			if (j == LDIV_STAGES + 1) begin : g_first
				assign lim_in  = lq_sn[LDIV_STAGES];
				assign root_in = '0;
			end else begin : g_next
				assign lim_in  = lim_sn[j-1];
				assign root_in = root_sn[j-1];
			end
			assign trial    = root_in | (ROOT_W'(1) << (NREG - j));
			assign trial_sq = trial * trial;
			always_ff @(posedge clk) begin
				if (adv) begin
					lim_sn[j]  <= lim_in;
					root_sn[j] <= (trial_sq <= (2*ROOT_W)'(lim_in)) ? trial : root_in;
				end
			end
		end
	end

	// output register: sign, error from the root, empty-weight case
	logic [ROOT_W:0]          err_c;
	logic signed [TIME_W-1:0] mean_c;

	always_comb begin
		err_c = (ROOT_W+1)'((ROOT_W+1)'(root_sn[NREG]) + 1'b1) >> 1;
		if (neg_sn[NREG]) mean_c = -$signed(mq_sn[NREG]);
		else if (mq_sn[NREG] > MQ_W'(MEAN_MAX)) mean_c = MEAN_MAX;
		else mean_c = $signed(mq_sn[NREG]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= v_sn[NREG];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_sn[NREG]) begin
				out_q.mean_time       <= '0;
				out_q.mean_time_error <= '0;
				out_q.time_chi_square <= '0;
				out_q.no_planes       <= 1'b1;
			end else begin
				out_q.mean_time <= mean_c;
				if (err_c > (ROOT_W+1)'(ERR_MAX)) out_q.mean_time_error <= ERR_MAX;
				else out_q.mean_time_error <= err_c[ERR_W-1:0];
				out_q.time_chi_square <= chi_sn[NREG];
				out_q.no_planes       <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the weighted track time fit
// Drives directed and random tracks under several idling phases and register
// settings, predicts each result in integer arithmetic unless a row gives it, and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import wttf_pkg::*;

	localparam int LATENCY   = 55;
	localparam int N_RANDOM  = 1630;
	localparam int CYCLE_CAP = 400000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_data;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// register copies held by the predictor
	logic [CFG_W-1:0] inv_lo, inv_hi, off_lo, off_hi;

	out_item_t fit_queue[$];
	int        mismatches;
	int        cycles;
	int        send_idle_pct;
	int        recv_stall_pct;

	weighted_track_time_fit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// rounded 2^15 / sqrt(s): largest e with (2e-1)^2 * s <= 2^32
	function automatic logic [ERR_W-1:0] error_of_weight(longint unsigned s);
		longint unsigned lim, lo, hi, mid, t;
		lim = (64'd1 << 32) / s;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t = 2 * mid - 1;
			if (t * t <= lim) lo = mid;
			else hi = mid - 1;
		end
		return (lo > 65535) ? ERR_MAX : lo[ERR_W-1:0];
	endfunction

	function automatic out_item_t fit_track(in_item_t it);
		out_item_t r;
		logic signed [TIME_W-1:0] hits[NUM_PLANES];
		longint          ref_t, t, d, mean;
		longint          num;
		longint unsigned sumw, acc, inv, w, ad, p, an, den, q, chi;
		logic [15:0]     lane_r, lane_o;
		bit              sat;
		hits[0] = it.hit_time_0; hits[1] = it.hit_time_1; hits[2] = it.hit_time_2;
		hits[3] = it.hit_time_3; hits[4] = it.hit_time_4; hits[5] = it.hit_time_5;
		ref_t = it.reference_time;
		sumw = 0; num = 0; acc = 0; sat = 0;
		for (int i = 0; i < NUM_PLANES; i++) begin
			if (it.present_mask[i]) begin
				lane_r = (i < 3) ? inv_lo[16*i +: 16] : inv_hi[16*(i-3) +: 16];
				lane_o = (i < 3) ? off_lo[16*i +: 16] : off_hi[16*(i-3) +: 16];
				t = hits[i];
				inv = lane_r;
				w = inv * inv;
				sumw += w;
				num += (t + ref_t) * longint'(w);
				d = t - ref_t - longint'($signed(lane_o));
				ad = (d < 0) ? -d : d;
				p = ad * inv;
				if (p >= (64'd1 << 24)) sat = 1;
				else acc += p * p;
			end
		end
		r = '0;
		if (sumw == 0) begin
			r.no_planes = 1'b1;
			return r;
		end
		den = 2 * sumw;
		an = (num < 0) ? -num : num;
		q = (2 * an + den) / (2 * den);
		mean = (num < 0) ? -longint'(q) : longint'(q);
		if (mean > 524287) mean = 524287;
		if (mean < -524288) mean = -524288;
		chi = (acc + (64'd1 << 23)) >> 24;
		if (sat || chi > 16777215) chi = 16777215;
		r.mean_time = mean[TIME_W-1:0];
		r.mean_time_error = error_of_weight(sumw);
		r.time_chi_square = chi[CHI_W-1:0];
		return r;
	endfunction

	// result checking and receiver stalls
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (fit_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", out_data);
				end else begin
					want = fit_queue.pop_front();
					if (out_data.mean_time !== want.mean_time
							|| out_data.mean_time_error !== want.mean_time_error
							|| out_data.time_chi_square !== want.time_chi_square
							|| out_data.no_planes !== want.no_planes) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %h actual %h", want, out_data);
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_INV_LOW:  inv_lo = val;
			REG_INV_HIGH: inv_hi = val;
			REG_OFF_LOW:  off_lo = val;
			REG_OFF_HIGH: off_hi = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain_fits();
		in_valid <= 1'b0;
		while (fit_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// one track transfer, with random idle cycles ahead of it
	task automatic send_track(in_item_t it, bit has_want, out_item_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		fit_queue.insert(fit_queue.size(), has_want ? want : fit_track(it));
	endtask

	function automatic logic [19:0] rand_time(int spread);
		case ($urandom_range(3))
			0: return 20'($urandom());
			1: return $urandom_range(1) ? 20'h7FFFF : 20'h80000;
			default: return 20'($signed(int'($urandom_range(2 * spread)) - spread));
		endcase
	endfunction

	function automatic in_item_t rand_track();
		in_item_t it;
		logic [19:0] base;
		base = 20'($urandom());
		it.reference_time = base;
		// mostly the reference plus a random offset, otherwise a random time alone
		it.hit_time_0 = $urandom_range(3) ? base + rand_time(300) : rand_time(1000);
		it.hit_time_1 = $urandom_range(3) ? base + rand_time(300) : rand_time(1000);
		it.hit_time_2 = $urandom_range(3) ? base + rand_time(300) : rand_time(1000);
		it.hit_time_3 = $urandom_range(3) ? base + rand_time(300) : rand_time(1000);
		it.hit_time_4 = $urandom_range(3) ? base + rand_time(300) : rand_time(1000);
		it.hit_time_5 = $urandom_range(3) ? base + rand_time(300) : rand_time(1000);
		it.present_mask = 6'($urandom());
		return it;
	endfunction

	function automatic logic [CFG_W-1:0] rand_inv();
		case ($urandom_range(3))
			0: return CFG_W'({$urandom(), $urandom()});
			1: return {16'($urandom_range(8192)), 16'($urandom_range(8192)),
				16'($urandom_range(8192))};
			2: return {3{16'hFFFF}};
			default: return {16'($urandom_range(600)), 16'($urandom_range(600)),
				16'($urandom_range(600))};
		endcase
	endfunction

	typedef struct {
		in_item_t  it;
		bit        has_want;
		out_item_t want;
	} track_row_t;

	track_row_t rows[$];

	initial begin
		track_row_t row;
		in_item_t   it;
		out_item_t  none;
		send_idle_pct = 0; recv_stall_pct = 0;
		arst_n = 1'b0; in_valid = 1'b0; in_data = '0;
		cfg_we = 1'b0; cfg_index = REG_INV_LOW; cfg_data = '0;
		inv_lo = '0; inv_hi = '0; off_lo = '0; off_hi = '0;
		none = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset every weight is zero: no planes flagged
		row.it = '{20'h12345, 20'h7FFFF, 20'h80000, 20'd0, 20'd1, 20'hFFFFF, 20'd7, 6'h3F};
		row.has_want = 1; row.want = '{20'd0, 16'd0, 24'd0, 1'b1};
		rows.insert(rows.size(), row);
		foreach (rows[k]) send_track(rows[k].it, rows[k].has_want, rows[k].want);
		drain_fits();

		// unit weights, zero offsets
		write_reg(REG_INV_LOW, {3{16'h1000}});
		write_reg(REG_INV_HIGH, {3{16'h1000}});
		write_reg(REG_OFF_LOW, '0);
		write_reg(REG_OFF_HIGH, '0);
		rows.delete();
		// empty mask
		row.it = '{20'd100, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'd6, 6'h00};
		row.has_want = 1; row.want = '{20'd0, 16'd0, 24'd0, 1'b1};
		rows.insert(rows.size(), row);
		// one plane equal to the reference: weight 2^24, error 8, chi zero
		row.it = '{20'd160, 20'd160, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 6'h01};
		row.want = '{20'd160, 16'd8, 24'd0, 1'b0};
		rows.insert(rows.size(), row);
		row.has_want = 0;
		// extremes of the times, rounding halves
		row.it = '{20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF,
			20'h7FFFF, 6'h3F};
		rows.insert(rows.size(), row);
		row.it = '{20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h80000,
			20'h80000, 6'h3F};
		rows.insert(rows.size(), row);
		row.it = '{20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF,
			20'h7FFFF, 6'h2A};
		rows.insert(rows.size(), row);
		row.it = '{20'd0, 20'd1, 20'hFFFFF, 20'd3, 20'hFFFFD, 20'd0, 20'd0, 6'h15};
		rows.insert(rows.size(), row);
		for (int b = 0; b < 6; b++) begin
			row.it = '{20'd5, 20'd9, 20'd17, 20'd33, 20'd65, 20'd129, 20'd257, 6'(1 << b)};
			rows.insert(rows.size(), row);
		end
		foreach (rows[k]) send_track(rows[k].it, rows[k].has_want, rows[k].want);
		drain_fits();

		// extreme weights and offsets: chi saturates, error at its floor
		write_reg(REG_INV_LOW, {3{16'hFFFF}});
		write_reg(REG_INV_HIGH, {16'h0000, 16'hFFFF, 16'h0001});
		write_reg(REG_OFF_LOW, {16'h7FFF, 16'h8000, 16'hFFFF});
		write_reg(REG_OFF_HIGH, {16'h0001, 16'h8000, 16'h7FFF});
		rows.delete();
		row.has_want = 0;
		row.it = '{20'd0, 20'h7FFFF, 20'h80000, 20'd0, 20'd1, 20'd2, 20'd3, 6'h3F};
		rows.insert(rows.size(), row);
		row.it = '{20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000,
			20'h7FFFF, 6'h38};
		rows.insert(rows.size(), row);
		// the only present plane has zero weight
		row.it = '{20'd10, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd20, 6'h20};
		row.has_want = 1; row.want = '{20'd0, 16'd0, 24'd0, 1'b1};
		rows.insert(rows.size(), row);
		// smallest weight: largest error
		row.it = '{20'd10, 20'd0, 20'd0, 20'd0, 20'd12, 20'd0, 20'd0, 6'h08};
		row.has_want = 0;
		rows.insert(rows.size(), row);
		foreach (rows[k]) send_track(rows[k].it, rows[k].has_want, rows[k].want);
		drain_fits();

		// random phases with fresh register settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			write_reg(REG_INV_LOW, rand_inv());
			write_reg(REG_INV_HIGH, rand_inv());
			write_reg(REG_OFF_LOW, CFG_W'({$urandom(), $urandom()}));
			write_reg(REG_OFF_HIGH, (ph == 7) ? '0 : CFG_W'({$urandom(), $urandom()}));
			for (int n = 0; n < N_RANDOM / 8; n++) begin
				it = rand_track();
				send_track(it, 0, none);
				// once in each phase, hold off until everything has come back
				if (n == 100) begin
					in_valid <= 1'b0;
					while (fit_queue.size() != 0) @(posedge clk);
				end
			end
			drain_fits();
		end

		recv_stall_pct = 0;
		if (mismatches == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

endmodule
